@@ rtl/fpbm_pkg.sv @@
// ----------------------------------------------------------------------------
// fpbm_pkg
// Shared types, constants and the FNV-1a mixing step for the percentage
// bucketing block.
// ----------------------------------------------------------------------------
package fpbm_pkg;

  localparam int unsigned IdentBytes = 16;
  localparam int unsigned IdentWidth = IdentBytes * 8;
  // Identifier bytes, then the domain byte, then the variant byte.
  localparam int unsigned MixStages  = IdentBytes + 2;

  localparam logic [31:0] FnvBasis = 32'd2166136261;
  localparam logic [31:0] FnvPrime = 32'd16777619;

  localparam logic [6:0]  BucketCount  = 7'd100;
  // floor(n / 100) == (n * Div100Magic) >> Div100Shift for every 32-bit n.
  localparam logic [31:0] Div100Magic  = 32'h51EB_851F;
  localparam int unsigned Div100Shift  = 37;

  typedef enum logic [7:0] {
    CFG_GROUP_ENABLED   = 8'd0,
    CFG_ROLLOUT_PERCENT = 8'd1,
    CFG_DOMAIN_BYTE     = 8'd2,
    CFG_VARIANT_BYTE    = 8'd3
  } cfg_reg_e;

  function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FnvPrime;
  endfunction

endpackage

@@ rtl/fnv1a_percent_bucket_member.sv @@
// ----------------------------------------------------------------------------
// fnv1a_percent_bucket_member
// Canary rollout membership from a 32-bit FNV-1a hash of a 128-bit device
// identifier, reduced modulo 100 to a bucket.
// ----------------------------------------------------------------------------
// The block accepts one identifier per clock while the output side does not
// stall and returns one bucket/member result per identifier, in order:
// eighteen stages mix in one byte each (sixteen identifier bytes, the domain
// byte, the variant byte), one stage forms the reciprocal product for the
// division by 100, one forms the remainder and one holds the result with its
// membership decision. Empty stages close up while the output waits, so
// items keep entering until the pipeline is full.
// Configuration must be written only while no item is in flight.
module fnv1a_percent_bucket_member
  import fpbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] ident_high_i,
  input  logic [63:0] ident_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [6:0]  bucket_o,
  output logic        member_o
);

  logic       group_enabled_q;
  logic [6:0] rollout_percent_q;
  logic [7:0] domain_byte_q;
  logic [7:0] variant_byte_q;

  logic        hash_valid;
  logic        hash_ready;
  logic [31:0] hash;

  logic        prod_valid_q;
  logic [31:0] prod_hash_q;
  logic [63:0] prod_q;
  logic        rem_valid_q;
  logic [6:0]  rem_q;
  logic        out_valid_q;
  logic [6:0]  bucket_q;
  logic        member_q;
  logic        member_d;

  logic        out_stage_ready;
  logic        rem_stage_ready;
  logic        prod_stage_ready;
  logic [26:0] quot;
  logic [31:0] rem_full;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_enabled_q   <= 1'b0;
      rollout_percent_q <= '0;
      domain_byte_q     <= '0;
      variant_byte_q    <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_GROUP_ENABLED: begin
          group_enabled_q <= cfg_data_i[0];
        end
        CFG_ROLLOUT_PERCENT: begin
          rollout_percent_q <= (cfg_data_i[6:0] > BucketCount) ? BucketCount
                                                               : cfg_data_i[6:0];
        end
        CFG_DOMAIN_BYTE: begin
          domain_byte_q <= cfg_data_i;
        end
        CFG_VARIANT_BYTE: begin
          variant_byte_q <= cfg_data_i;
        end
        default: begin
        end
      endcase
    end
  end

  fpbm_hash_pipe u_hash_pipe (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .ident_high_i   (ident_high_i),
    .ident_low_i    (ident_low_i),
    .domain_byte_i  (domain_byte_q),
    .variant_byte_i (variant_byte_q),
    .out_valid_o    (hash_valid),
    .out_ready_i    (hash_ready),
    .hash_o         (hash)
  );

  assign out_stage_ready  = !out_valid_q || out_ready_i;
  assign rem_stage_ready  = !rem_valid_q || out_stage_ready;
  assign prod_stage_ready = !prod_valid_q || rem_stage_ready;
  assign hash_ready       = prod_stage_ready;

  // Quotient by 100 from the reciprocal product, then the remainder.
  assign quot     = prod_q[63:Div100Shift];
  assign rem_full = prod_hash_q - ({5'd0, quot} * {25'd0, BucketCount});

  always_comb begin
    priority if (!group_enabled_q || rollout_percent_q == '0) begin
      member_d = 1'b0;
    end else if (rollout_percent_q >= BucketCount) begin
      member_d = 1'b1;
    end else begin
      member_d = (rem_q < rollout_percent_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      rem_valid_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (prod_stage_ready) begin
        prod_valid_q <= hash_valid;
      end
      if (rem_stage_ready) begin
        rem_valid_q <= prod_valid_q;
      end
      if (out_stage_ready) begin
        out_valid_q <= rem_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (prod_stage_ready && hash_valid) begin
      prod_hash_q <= hash;
      prod_q      <= {32'd0, hash} * {32'd0, Div100Magic};
    end
    if (rem_stage_ready && prod_valid_q) begin
      rem_q <= rem_full[6:0];
    end
    if (out_stage_ready && rem_valid_q) begin
      bucket_q <= rem_q;
      member_q <= member_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign bucket_o    = bucket_q;
  assign member_o    = member_q;

  // The reciprocal step must always leave a remainder below 100.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_valid_q |-> (rem_q < BucketCount))
    else $error("remainder stage produced a bucket of 100 or more");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && member_o) |-> (group_enabled_q && rollout_percent_q != '0))
    else $error("member reported while the group is inactive or at zero percent");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rollout_percent_q <= BucketCount)
    else $error("rollout percent register holds a value above 100");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_valid_q && !out_stage_ready) |=> (rem_valid_q && $stable(rem_q)))
    else $error("remainder stage lost or changed an item during a stall");

endmodule

@@ rtl/fpbm_hash_pipe.sv @@
// ----------------------------------------------------------------------------
// fpbm_hash_pipe
// Eighteen-stage FNV-1a pipeline: one byte is mixed in per stage, sixteen
// identifier bytes followed by the domain byte and the variant byte.
// ----------------------------------------------------------------------------
module fpbm_hash_pipe
  import fpbm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] ident_high_i,
  input  logic [63:0] ident_low_i,
  input  logic [7:0]  domain_byte_i,
  input  logic [7:0]  variant_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] hash_o
);

  logic [MixStages-1:0]  valid_q;
  logic [MixStages:0]    stage_ready;
  logic [31:0]           hash_q  [MixStages];
  logic [IdentWidth-1:0] ident_q [MixStages];

  // A stage takes a new item when it is empty or its item moves on.
  assign stage_ready[MixStages] = out_ready_i;

  for (genvar k = 0; k < MixStages; k++) begin : g_stage
    logic                  up_valid;
    logic [31:0]           up_hash;
    logic [IdentWidth-1:0] up_ident;
    logic [7:0]            mix_byte;

    assign stage_ready[k] = !valid_q[k] || stage_ready[k+1];

    if (k == 0) begin : g_first
      assign up_valid = in_valid_i;
      assign up_hash  = FnvBasis;
      assign up_ident = {ident_high_i, ident_low_i};
    end else begin : g_next
      assign up_valid = valid_q[k-1];
      assign up_hash  = hash_q[k-1];
      assign up_ident = ident_q[k-1];
    end

    if (k < IdentBytes) begin : g_ident_byte
      assign mix_byte = up_ident[IdentWidth-1-8*k -: 8];
    end else if (k == IdentBytes) begin : g_domain_byte
      assign mix_byte = domain_byte_i;
    end else begin : g_variant_byte
      assign mix_byte = variant_byte_i;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (stage_ready[k]) begin
        valid_q[k] <= up_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (stage_ready[k] && up_valid) begin
        hash_q[k]  <= fnv_mix(up_hash, mix_byte);
        ident_q[k] <= up_ident;
      end
    end
  end

  assign in_ready_o  = stage_ready[0];
  assign out_valid_o = valid_q[MixStages-1];
  assign hash_o      = hash_q[MixStages-1];

endmodule
